// ===== rtl/core/pts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the process table scheduler
package pts_pkg;

    // sizes
    localparam int PROC_SLOTS  = 32;
    localparam int CHILD_SLOTS = 8;
    localparam int PID_W       = $clog2(PROC_SLOTS);
    localparam int XPID_W      = PID_W + 1;
    localparam int CS_W        = $clog2(CHILD_SLOTS);
    localparam int CNT_W       = $clog2(CHILD_SLOTS + 1);
    localparam int CODE_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 3;
    localparam int LIST_DEPTH  = PROC_SLOTS * CHILD_SLOTS;
    localparam int LIST_AW     = PID_W + CS_W;
    localparam int EXREC_W     = PID_W + CODE_W;

    localparam logic [XPID_W-1:0]       PID_NONE    = XPID_W'(PROC_SLOTS);
    localparam logic [CNT_W-1:0]        CNT_FULL    = CNT_W'(CHILD_SLOTS);
    localparam logic signed [CODE_W-1:0] RCODE_NONE = -32'sd1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SCHED = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUSP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXIT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOTHING = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND   = 3'd2;
    localparam logic [STAT_W-1:0] ST_RUNNING = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SCHED,
        OP_SUSP,
        OP_EXIT,
        OP_WAIT,
        OP_NOP
    } t_op;

    // classified command passed from front to back
    typedef struct packed {
        t_op                       op;
        logic [PID_W-1:0]          pid;
        logic [XPID_W-1:0]         parent;
        logic signed [CODE_W-1:0]  code;
        logic [XPID_W-1:0]         want;
    } t_cmd;

    // one result transaction
    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic [XPID_W-1:0]         rpid;
        logic signed [CODE_W-1:0]  rcode;
        logic [XPID_W-1:0]         cur;
    } t_res;

    // exited child record
    typedef struct packed {
        logic [PID_W-1:0]          pid;
        logic signed [CODE_W-1:0]  code;
    } t_exit_rec;

endpackage

// ===== rtl/core/pts_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual port RAM with registered read
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/pts_front.sv =====
`timescale 1ns / 1ps
// Front end: command decode and two-entry queue towards the sequencer
module pts_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [pts_pkg::CMD_W-1:0]     i_command,
    input  logic [pts_pkg::PID_W-1:0]     i_pid,
    input  logic [pts_pkg::XPID_W-1:0]    i_parent_pid,
    input  logic signed [pts_pkg::CODE_W-1:0] i_exit_code,
    input  logic [pts_pkg::XPID_W-1:0]    i_child_pid,
    output logic                          o_valid,
    output pts_pkg::t_cmd                 o_item,
    input  logic                          i_take
);
    import pts_pkg::*;

    t_cmd       cls;
    t_cmd       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push_ok, take_ok;

    // decode the command and fold out-of-range parents to none
    always_comb begin
        cls.pid    = i_pid;
        cls.parent = i_parent_pid[XPID_W-1] ? PID_NONE : i_parent_pid;
        cls.code   = i_exit_code;
        cls.want   = i_child_pid;
        case (i_command)
            CMD_ADD:   cls.op = OP_ADD;
            CMD_SCHED: cls.op = OP_SCHED;
            CMD_SUSP:  cls.op = OP_SUSP;
            CMD_EXIT:  cls.op = OP_EXIT;
            CMD_WAIT:  cls.op = OP_WAIT;
            default:   cls.op = OP_NOP;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rd];
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_valid;

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= !r_wr;
            end
            if (take_ok) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, take_ok};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr] <= cls;
        end
    end
endmodule

// ===== rtl/core/pts_back.sv =====
`timescale 1ns / 1ps
// Back end: sequencer over the process table, ready ring and child lists
module pts_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pts_pkg::t_cmd i_item,
    output logic          o_take,
    output logic          o_res_valid,
    output pts_pkg::t_res o_res,
    input  logic          i_res_ready
);
    import pts_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_SCHED     = 13'b0000000000010,
        S_XSCAN_RD  = 13'b0000000000100,
        S_XSCAN_CK  = 13'b0000000001000,
        S_XRINIT    = 13'b0000000010000,
        S_XREP_RD   = 13'b0000000100000,
        S_XREP_CK   = 13'b0000001000000,
        S_XFIN      = 13'b0000010000000,
        S_WANY      = 13'b0000100000000,
        S_WSCAN_RD  = 13'b0001000000000,
        S_WSCAN_CK  = 13'b0010000000000,
        S_WLIVE_RD  = 13'b0100000000000,
        S_WLIVE_CK  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out, n_out;
    t_cmd   r_cmd, n_cmd;

    logic [XPID_W-1:0]  r_cur, n_cur;
    logic [PID_W-1:0]   r_head, n_head, r_tail, n_tail;
    logic [XPID_W-1:0]  r_parent [PROC_SLOTS];
    logic [CNT_W-1:0]   r_lcc    [PROC_SLOTS];
    logic [CNT_W-1:0]   r_ecnt   [PROC_SLOTS];
    logic [CNT_W-1:0]   r_k, n_k, r_n, n_n;
    logic [PID_W-1:0]   r_owner, n_owner;
    logic               r_found, n_found;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [XPID_W-1:0]  r_rpid, n_rpid;
    logic signed [CODE_W-1:0] r_rcode, n_rcode;

    // table write ports
    logic                par_we;
    logic [PID_W-1:0]    par_wa;
    logic [XPID_W-1:0]   par_wd;
    logic                lcc0_we, lcc1_we, ec_we;
    logic [PID_W-1:0]    lcc0_wa, lcc1_wa, ec_wa;
    logic [CNT_W-1:0]    lcc0_wd, lcc1_wd, ec_wd;

    // memory ports
    logic                ring_we;
    logic [PID_W-1:0]    ring_wd, ring_rd;
    logic                live_we;
    logic [LIST_AW-1:0]  live_wa, live_ra;
    logic [PID_W-1:0]    live_wd, live_rd;
    logic                ex_we;
    logic [LIST_AW-1:0]  ex_wa, ex_ra;
    t_exit_rec           ex_wd, ex_rd;
    logic [EXREC_W-1:0]  ex_rd_raw;

    logic [PID_W-1:0]    cur_pid, add_par, next_tail;
    logic [CNT_W-1:0]    add_n, cur_d, cur_n, k_prev, k_next, n0;
    logic                ring_full;

    // index of the last entry of a non-empty list
    function automatic logic [CS_W-1:0] k_prev_any(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] last;
        last = cnt - CNT_W'(1);
        return last[CS_W-1:0];
    endfunction

    assign cur_pid   = r_cur[PID_W-1:0];
    assign add_par   = i_item.parent[PID_W-1:0];
    assign add_n     = (add_par == i_item.pid) ? '0 : r_lcc[add_par];
    assign next_tail = r_tail + PID_W'(1);
    assign ring_full = (next_tail == r_head);
    assign cur_d     = r_ecnt[cur_pid];
    assign cur_n     = r_lcc[cur_pid];
    assign k_prev    = r_k - CNT_W'(1);
    assign k_next    = r_k + CNT_W'(1);
    assign n0        = r_lcc[0];
    assign ex_rd     = ex_rd_raw;

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_out    = r_out;
        n_cmd    = r_cmd;
        n_cur    = r_cur;
        n_head   = r_head;
        n_tail   = r_tail;
        n_k      = r_k;
        n_n      = r_n;
        n_owner  = r_owner;
        n_found  = r_found;
        n_status = r_status;
        n_rpid   = r_rpid;
        n_rcode  = r_rcode;
        o_take   = 1'b0;
        par_we   = 1'b0;
        par_wa   = '0;
        par_wd   = '0;
        lcc0_we  = 1'b0;
        lcc0_wa  = '0;
        lcc0_wd  = '0;
        lcc1_we  = 1'b0;
        lcc1_wa  = '0;
        lcc1_wd  = '0;
        ec_we    = 1'b0;
        ec_wa    = '0;
        ec_wd    = '0;
        ring_we  = 1'b0;
        ring_wd  = '0;
        live_we  = 1'b0;
        live_wa  = '0;
        live_wd  = '0;
        live_ra  = '0;
        ex_we    = 1'b0;
        ex_wa    = '0;
        ex_wd    = '0;
        ex_ra    = '0;

        if (r_out) begin
            // hold the result until the output stage takes it
            if (i_res_ready) begin
                n_out = 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        o_take   = 1'b1;
                        n_cmd    = i_item;
                        n_status = ST_NOTHING;
                        n_rpid   = PID_NONE;
                        n_rcode  = RCODE_NONE;
                        n_k      = '0;
                        n_found  = 1'b0;
                        case (i_item.op)
                            OP_ADD: begin
                                par_we  = 1'b1;
                                par_wa  = i_item.pid;
                                par_wd  = i_item.parent;
                                lcc0_we = 1'b1;
                                lcc0_wa = i_item.pid;
                                ec_we   = 1'b1;
                                ec_wa   = i_item.pid;
                                if (i_item.parent != PID_NONE && add_n < CNT_FULL) begin
                                    live_we = 1'b1;
                                    live_wa = {add_par, add_n[CS_W-1:0]};
                                    live_wd = i_item.pid;
                                    lcc1_we = 1'b1;
                                    lcc1_wa = add_par;
                                    lcc1_wd = add_n + CNT_W'(1);
                                end
                                if (ring_full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    ring_we  = 1'b1;
                                    ring_wd  = i_item.pid;
                                    n_tail   = next_tail;
                                    n_status = ST_DONE;
                                end
                                n_out = 1'b1;
                            end
                            OP_SCHED: begin
                                if (r_head != r_tail) begin
                                    n_state = S_SCHED;
                                end else begin
                                    n_out = 1'b1;
                                end
                            end
                            OP_SUSP: begin
                                if (r_cur != PID_NONE) begin
                                    if (ring_full) begin
                                        n_status = ST_FULL;
                                    end else begin
                                        ring_we  = 1'b1;
                                        ring_wd  = cur_pid;
                                        n_tail   = next_tail;
                                        n_status = ST_DONE;
                                    end
                                    n_cur = PID_NONE;
                                end
                                n_out = 1'b1;
                            end
                            OP_EXIT: begin
                                if (r_cur == PID_NONE) begin
                                    n_out = 1'b1;
                                end else if (r_parent[cur_pid] != PID_NONE) begin
                                    n_owner = r_parent[cur_pid][PID_W-1:0];
                                    n_n     = r_lcc[r_parent[cur_pid][PID_W-1:0]];
                                    n_state = S_XSCAN_RD;
                                end else begin
                                    n_state = S_XRINIT;
                                end
                            end
                            OP_WAIT: begin
                                if (r_cur == PID_NONE) begin
                                    n_out = 1'b1;
                                end else if (i_item.want == PID_NONE) begin
                                    if (cur_d != '0) begin
                                        ex_ra   = {cur_pid, k_prev_any(cur_d)};
                                        ec_we   = 1'b1;
                                        ec_wa   = cur_pid;
                                        ec_wd   = cur_d - CNT_W'(1);
                                        n_state = S_WANY;
                                    end else begin
                                        if (cur_n != '0) begin
                                            n_status = ST_RUNNING;
                                        end
                                        n_out = 1'b1;
                                    end
                                end else begin
                                    n_n     = cur_d;
                                    n_state = S_WSCAN_RD;
                                end
                            end
                            default: begin
                                n_out = 1'b1;
                            end
                        endcase
                    end
                end
                // ring data for the head entry is back
                S_SCHED: begin
                    n_rpid   = {1'b0, ring_rd};
                    n_cur    = {1'b0, ring_rd};
                    n_head   = r_head + PID_W'(1);
                    n_status = ST_DONE;
                    n_state  = S_IDLE;
                    n_out    = 1'b1;
                end
                // walk the parent's live list, drop the exiting pid
                S_XSCAN_RD: begin
                    if (r_k < r_n) begin
                        live_ra = {r_owner, r_k[CS_W-1:0]};
                        n_state = S_XSCAN_CK;
                    end else begin
                        if (r_found) begin
                            lcc0_we = 1'b1;
                            lcc0_wa = r_owner;
                            lcc0_wd = r_n - CNT_W'(1);
                        end
                        n_state = S_XRINIT;
                    end
                end
                S_XSCAN_CK: begin
                    if (r_found) begin
                        live_we = 1'b1;
                        live_wa = {r_owner, k_prev[CS_W-1:0]};
                        live_wd = live_rd;
                    end else if (live_rd == cur_pid) begin
                        n_found = 1'b1;
                        if (r_ecnt[r_owner] < CNT_FULL) begin
                            ex_we   = 1'b1;
                            ex_wa   = {r_owner, r_ecnt[r_owner][CS_W-1:0]};
                            ex_wd   = '{pid: cur_pid, code: r_cmd.code};
                            ec_we   = 1'b1;
                            ec_wa   = r_owner;
                            ec_wd   = r_ecnt[r_owner] + CNT_W'(1);
                        end
                    end
                    n_k     = k_next;
                    n_state = S_XSCAN_RD;
                end
                S_XRINIT: begin
                    n_k     = '0;
                    n_n     = cur_n;
                    n_state = S_XREP_RD;
                end
                // hand each live child over to process 0
                S_XREP_RD: begin
                    if (r_k < r_n) begin
                        live_ra = {cur_pid, r_k[CS_W-1:0]};
                        n_state = S_XREP_CK;
                    end else begin
                        n_state = S_XFIN;
                    end
                end
                S_XREP_CK: begin
                    par_we = 1'b1;
                    par_wa = live_rd;
                    par_wd = '0;
                    if (n0 < CNT_FULL) begin
                        live_we = 1'b1;
                        live_wa = {PID_W'(0), n0[CS_W-1:0]};
                        live_wd = live_rd;
                        lcc0_we = 1'b1;
                        lcc0_wa = '0;
                        lcc0_wd = n0 + CNT_W'(1);
                    end
                    n_k     = k_next;
                    n_state = S_XREP_RD;
                end
                S_XFIN: begin
                    par_we   = 1'b1;
                    par_wa   = cur_pid;
                    par_wd   = '0;
                    lcc0_we  = 1'b1;
                    lcc0_wa  = cur_pid;
                    ec_we    = 1'b1;
                    ec_wa    = cur_pid;
                    n_cur    = PID_NONE;
                    n_status = ST_DONE;
                    n_state  = S_IDLE;
                    n_out    = 1'b1;
                end
                // most recent exited child
                S_WANY: begin
                    n_rpid   = {1'b0, ex_rd.pid};
                    n_rcode  = ex_rd.code;
                    n_status = ST_FOUND;
                    n_state  = S_IDLE;
                    n_out    = 1'b1;
                end
                // search the exited list, compacting behind the match
                S_WSCAN_RD: begin
                    if (r_k < r_n) begin
                        ex_ra   = {cur_pid, r_k[CS_W-1:0]};
                        n_state = S_WSCAN_CK;
                    end else if (r_found) begin
                        ec_we    = 1'b1;
                        ec_wa    = cur_pid;
                        ec_wd    = r_n - CNT_W'(1);
                        n_status = ST_FOUND;
                        n_state  = S_IDLE;
                        n_out    = 1'b1;
                    end else begin
                        n_k     = '0;
                        n_n     = cur_n;
                        n_state = S_WLIVE_RD;
                    end
                end
                S_WSCAN_CK: begin
                    if (r_found) begin
                        ex_we = 1'b1;
                        ex_wa = {cur_pid, k_prev[CS_W-1:0]};
                        ex_wd = ex_rd;
                    end else if ({1'b0, ex_rd.pid} == r_cmd.want) begin
                        n_found = 1'b1;
                        n_rpid  = r_cmd.want;
                        n_rcode = ex_rd.code;
                    end
                    n_k     = k_next;
                    n_state = S_WSCAN_RD;
                end
                // search the live list for a running child
                S_WLIVE_RD: begin
                    if (r_k < r_n && !r_found) begin
                        live_ra = {cur_pid, r_k[CS_W-1:0]};
                        n_state = S_WLIVE_CK;
                    end else begin
                        n_status = r_found ? ST_RUNNING : ST_NOTHING;
                        n_state  = S_IDLE;
                        n_out    = 1'b1;
                    end
                end
                S_WLIVE_CK: begin
                    if ({1'b0, live_rd} == r_cmd.want) begin
                        n_found = 1'b1;
                    end
                    n_k     = k_next;
                    n_state = S_WLIVE_RD;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // control state and process tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out   <= 1'b0;
            r_cur   <= PID_NONE;
            r_head  <= '0;
            r_tail  <= '0;
            for (int i = 0; i < PROC_SLOTS; i++) begin
                r_parent[i] <= '0;
                r_lcc[i]    <= '0;
                r_ecnt[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_out   <= n_out;
            r_cur   <= n_cur;
            r_head  <= n_head;
            r_tail  <= n_tail;
            if (par_we) begin
                r_parent[par_wa] <= par_wd;
            end
            if (lcc0_we) begin
                r_lcc[lcc0_wa] <= lcc0_wd;
            end
            if (lcc1_we) begin
                r_lcc[lcc1_wa] <= lcc1_wd;
            end
            if (ec_we) begin
                r_ecnt[ec_wa] <= ec_wd;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_k      <= n_k;
        r_n      <= n_n;
        r_owner  <= n_owner;
        r_found  <= n_found;
        r_status <= n_status;
        r_rpid   <= n_rpid;
        r_rcode  <= n_rcode;
    end

    pts_ram #(.WIDTH(PID_W), .DEPTH(PROC_SLOTS)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_tail),
        .i_wdata (ring_wd),
        .i_raddr (r_head),
        .o_rdata (ring_rd)
    );

    pts_ram #(.WIDTH(PID_W), .DEPTH(LIST_DEPTH)) u_live (
        .i_clk   (i_clk),
        .i_we    (live_we),
        .i_waddr (live_wa),
        .i_wdata (live_wd),
        .i_raddr (live_ra),
        .o_rdata (live_rd)
    );

    pts_ram #(.WIDTH(EXREC_W), .DEPTH(LIST_DEPTH)) u_exited (
        .i_clk   (i_clk),
        .i_we    (ex_we),
        .i_waddr (ex_wa),
        .i_wdata (ex_wd),
        .i_raddr (ex_ra),
        .o_rdata (ex_rd_raw)
    );

    assign o_res_valid = r_out;
    assign o_res       = '{status: r_status, rpid: r_rpid, rcode: r_rcode, cur: r_cur};
endmodule

// ===== rtl/core/process_table_scheduler_core.sv =====
`timescale 1ns / 1ps
// Top level of the process table scheduler
//
// Commands enter through a queue-style port: a transaction is taken on a
// clock edge with push high and full low. Results leave the same way: the
// oldest result sits on the o_ ports while empty is low and is taken on an
// edge with pop high. Every command gives exactly one result.
// Add, suspend, unknown commands and an empty schedule finish from the
// idle state; schedule first reads the ready ring. Exit walks the parent's
// live list and then the exiting process's own list, with a read and a
// check state per entry, as the child list memories have one registered
// read port. Wait for one child walks the exited and live lists the same
// way; wait for any child reads the newest exited record. Results reach
// the ports through the output register. A two-entry command queue keeps
// taking commands while the sequencer works or a result waits, so a stalled
// receiver only stops the sequencer once its output register is full. Reset
// clears all tables and counts; ring and child lists need no clearing pass.
module process_table_scheduler_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [pts_pkg::CMD_W-1:0]         i_command,
    input  logic [pts_pkg::PID_W-1:0]         i_pid,
    input  logic [pts_pkg::XPID_W-1:0]        i_parent_pid,
    input  logic signed [pts_pkg::CODE_W-1:0] i_exit_code,
    input  logic [pts_pkg::XPID_W-1:0]        i_child_pid,
    output logic                              empty,
    input  logic                              pop,
    output logic [pts_pkg::STAT_W-1:0]        o_status,
    output logic [pts_pkg::XPID_W-1:0]        o_result_pid,
    output logic signed [pts_pkg::CODE_W-1:0] o_child_exit_code,
    output logic [pts_pkg::XPID_W-1:0]        o_current_pid
);
    import pts_pkg::*;

    t_cmd item;
    logic item_valid, item_take;
    t_res res, r_res;
    logic res_valid, res_ready, r_res_valid;

    pts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_command    (i_command),
        .i_pid        (i_pid),
        .i_parent_pid (i_parent_pid),
        .i_exit_code  (i_exit_code),
        .i_child_pid  (i_child_pid),
        .o_valid      (item_valid),
        .o_item       (item),
        .i_take       (item_take)
    );

    pts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .i_item      (item),
        .o_take      (item_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output register
    assign res_ready = !r_res_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_res_valid <= 1'b1;
        end else if (pop) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_res <= res;
        end
    end

    assign empty             = !r_res_valid;
    assign o_status          = r_res.status;
    assign o_result_pid      = r_res.rpid;
    assign o_child_exit_code = r_res.rcode;
    assign o_current_pid     = r_res.cur;

`ifndef SYNTHESIS
    a_found_has_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_FOUND) |-> (o_result_pid != PID_NONE))
        else $error("found result without a child pid");

    a_code_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_FOUND) |-> (o_child_exit_code == RCODE_NONE))
        else $error("exit code on a result that reaped nothing");

    a_sched_sets_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_DONE && o_result_pid != PID_NONE)
            |-> (o_current_pid == o_result_pid))
        else $error("scheduled pid is not the current pid");
`endif
endmodule
